[hw/rtl/bba_pkg.sv]
`default_nettype none
package bba_pkg;

	localparam int MAX_ORDER_DEF    = 16;
	localparam int MIN_ORDER_DEF    = 5;
	localparam int HEADER_BYTES_DEF = 8;

	localparam int SIZE_W  = 16;
	localparam int ADDR_W  = 16;
	localparam int ORDER_W = 5;
	localparam int STAT_W  = 2;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_NO_MEM   = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_BAD_FREE = 2'd2;

	localparam logic [ORDER_W-1:0] HEAP_ORDER_RST = 5'd16;

	// one entry per minimum-size granule
	typedef struct packed {
		logic               head;
		logic               free;
		logic [ORDER_W-1:0] order;
	} entry_t;

	// smallest k with 2^k >= n
	function automatic logic [ORDER_W-1:0] ceil_log2(input logic [SIZE_W:0] n);
		logic [SIZE_W:0]    m;
		logic [ORDER_W-1:0] r;
		m = n - 1'b1;
		r = '0;
		if (n > 1) begin
			for (int i = 0; i <= SIZE_W; i++) begin
				if (m[i]) r = ORDER_W'(i + 1);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/bba_req_if.sv]
`default_nettype none
interface bba_req_if import bba_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [SIZE_W-1:0] request_size;
	logic [ADDR_W-1:0] block_address;

	modport source(output valid, mode, request_size, block_address, input ready);
	modport sink(input valid, mode, request_size, block_address, output ready);
endinterface
`default_nettype wire

[hw/rtl/bba_rsp_if.sv]
`default_nettype none
interface bba_rsp_if import bba_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  address;
	logic [ORDER_W-1:0] granted_order;
	logic [STAT_W-1:0]  status;

	modport source(output valid, address, granted_order, status, input ready);
	modport sink(input valid, address, granted_order, status, output ready);
endinterface
`default_nettype wire

[hw/rtl/buddy_block_allocator_unit.sv]
// Allocate scans the blocks first-fit (read, then evaluate each), splits the chosen block
//   down to the wanted order and finishes; free checks the block, then probes buddies to merge.
// Throughput: one request at a time; the scan and merge loops share one table port.
// Reset (and any heap_order write) runs a clear pass over all 2^(MAX_ORDER-MIN_ORDER) table
//   entries, 2048 by default, during which no request is accepted.
// After the pass entry 0 holds one free block of the clamped heap order.
`default_nettype none
module buddy_block_allocator_unit import bba_pkg::*; #(
	parameter int MAX_ORDER    = MAX_ORDER_DEF,
	parameter int MIN_ORDER    = MIN_ORDER_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [ORDER_W-1:0] cfg_wr_data,
	bba_req_if.sink                 req,
	bba_rsp_if.source               rsp
);

	localparam int IW    = MAX_ORDER - MIN_ORDER;
	localparam int DEPTH = 1 << IW;
	localparam int CW    = (MAX_ORDER + 1 > ADDR_W + 1) ? MAX_ORDER + 1 : ADDR_W + 1;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_A_RD  = 4'd2;
	localparam logic [3:0] ST_A_EV  = 4'd3;
	localparam logic [3:0] ST_SPLIT = 4'd4;
	localparam logic [3:0] ST_F_RD  = 4'd5;
	localparam logic [3:0] ST_F_EV  = 4'd6;
	localparam logic [3:0] ST_M_RD  = 4'd7;
	localparam logic [3:0] ST_M_EV  = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;

	localparam logic [ORDER_W-1:0] MIN_O = ORDER_W'(MIN_ORDER);
	localparam logic [ORDER_W-1:0] MAX_O = ORDER_W'(MAX_ORDER);

	logic [3:0]         state_q;
	logic [IW-1:0]      clr_q;
	logic [ORDER_W-1:0] heap_order_q;
	logic [IW:0]        idx_q;
	logic [ORDER_W-1:0] ord_q, want_q;
	logic [ADDR_W-1:0]  res_addr_q;
	logic [ORDER_W-1:0] res_ord_q;
	logic [STAT_W-1:0]  res_stat_q;
	logic               out_valid_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [ORDER_W-1:0] out_ord_q;
	logic [STAT_W-1:0]  out_stat_q;
	// remembers whether the item in flight is a free (address field reads 0 then)
	logic               rsp_free_q;

	entry_t             mem [DEPTH];
	entry_t             rd_data_q;
	logic [IW-1:0]      rd_addr;
	logic               we;
	logic [IW-1:0]      wa;
	entry_t             wd;

	logic [ORDER_W-1:0] h;
	logic [IW:0]        count;
	logic               in_xfer, out_free;
	logic [ORDER_W-1:0] need_ord, want_in;
	logic [CW-1:0]      off_w, heap_bytes, user_addr;
	logic               free_bad;
	logic [IW-1:0]      bud, split_bud;
	logic [IW:0]        step;
	logic [ORDER_W-1:0] e_ord;
	logic               e_sane;

	// clamped heap order
	always_comb begin
		h = heap_order_q;
		if (h < MIN_O) h = MIN_O;
		if (h > MAX_O) h = MAX_O;
	end

	assign count    = (IW+1)'(1) << (h - MIN_O);
	assign in_xfer  = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	assign need_ord = ceil_log2((SIZE_W+1)'(req.request_size) + (SIZE_W+1)'(HEADER_BYTES));
	assign want_in  = (need_ord < MIN_O) ? MIN_O : need_ord;

	assign off_w      = CW'(req.block_address) - CW'(HEADER_BYTES);
	assign heap_bytes = CW'(1) << h;
	assign free_bad   = (CW'(req.block_address) < CW'(HEADER_BYTES)) || (off_w >= heap_bytes) ||
	                    (off_w[MIN_ORDER-1:0] != '0);

	assign bud       = idx_q[IW-1:0] ^ (IW'(1) << (ord_q - MIN_O));
	assign split_bud = idx_q[IW-1:0] + (IW'(1) << (ord_q - 1'b1 - MIN_O));
	assign e_ord     = rd_data_q.order;
	assign e_sane    = rd_data_q.head && (e_ord >= MIN_O) && (e_ord <= h);
	assign step      = (IW+1)'(1) << (e_ord - MIN_O);
	assign user_addr = (CW'(idx_q) << MIN_ORDER) + CW'(HEADER_BYTES);

	assign rd_addr = (state_q == ST_M_RD) ? bud : idx_q[IW-1:0];

	always_comb begin
		we = 1'b0;
		wa = idx_q[IW-1:0];
		wd = '0;
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				wa = clr_q;
				if (clr_q == '0) wd = '{head: 1'b1, free: 1'b1, order: h};
			end
			ST_SPLIT: begin
				we = 1'b1;
				if (ord_q > want_q) begin
					wa = split_bud;
					wd = '{head: 1'b1, free: 1'b1, order: ord_q - 1'b1};
				end else begin
					wd = '{head: 1'b1, free: 1'b0, order: ord_q};
				end
			end
			ST_M_RD: begin
				if (ord_q >= h) begin
					we = 1'b1;
					wd = '{head: 1'b1, free: 1'b1, order: ord_q};
				end
			end
			ST_M_EV: begin
				we = 1'b1;
				if (rd_data_q.head && rd_data_q.free && e_ord == ord_q) begin
					// drop the upper head of the pair
					wa = (bud < idx_q[IW-1:0]) ? idx_q[IW-1:0] : bud;
				end else begin
					wd = '{head: 1'b1, free: 1'b1, order: ord_q};
				end
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			heap_order_q <= HEAP_ORDER_RST;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			if (cfg_wr_en) begin
				heap_order_q <= cfg_wr_data;
				clr_q        <= '0;
				state_q      <= ST_CLEAR;
			end else begin
				case (state_q)
					ST_CLEAR: begin
						clr_q <= clr_q + 1'b1;
						if (clr_q == IW'(DEPTH - 1)) state_q <= ST_IDLE;
					end
					ST_IDLE: begin
						if (in_xfer) begin
							if (req.mode == MODE_ALLOC) begin
								want_q  <= want_in;
								idx_q   <= '0;
								state_q <= ST_A_RD;
							end else if (free_bad) begin
								res_stat_q <= STATUS_BAD_FREE;
								state_q    <= ST_FIN;
							end else begin
								idx_q   <= {1'b0, off_w[MAX_ORDER-1:MIN_ORDER]};
								state_q <= ST_F_RD;
							end
						end
					end
					ST_A_RD: begin
						if (want_q > h || idx_q >= count) begin
							res_stat_q <= STATUS_NO_MEM;
							state_q    <= ST_FIN;
						end else begin
							state_q <= ST_A_EV;
						end
					end
					ST_A_EV: begin
						if (!e_sane) begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_A_RD;
						end else if (rd_data_q.free && e_ord >= want_q) begin
							ord_q   <= e_ord;
							state_q <= ST_SPLIT;
						end else begin
							idx_q   <= idx_q + step;
							state_q <= ST_A_RD;
						end
					end
					ST_SPLIT: begin
						if (ord_q > want_q) begin
							ord_q <= ord_q - 1'b1;
						end else begin
							res_addr_q <= user_addr[ADDR_W-1:0];
							res_ord_q  <= ord_q;
							res_stat_q <= STATUS_OK;
							state_q    <= ST_FIN;
						end
					end
					ST_F_RD: state_q <= ST_F_EV;
					ST_F_EV: begin
						if (!e_sane || rd_data_q.free) begin
							res_stat_q <= STATUS_BAD_FREE;
							state_q    <= ST_FIN;
						end else begin
							ord_q   <= e_ord;
							state_q <= ST_M_RD;
						end
					end
					ST_M_RD: begin
						if (ord_q >= h) begin
							res_ord_q  <= ord_q;
							res_stat_q <= STATUS_OK;
							state_q    <= ST_FIN;
						end else begin
							state_q <= ST_M_EV;
						end
					end
					ST_M_EV: begin
						if (rd_data_q.head && rd_data_q.free && e_ord == ord_q) begin
							if (bud < idx_q[IW-1:0]) idx_q <= {1'b0, bud};
							ord_q   <= ord_q + 1'b1;
							state_q <= ST_M_RD;
						end else begin
							res_ord_q  <= ord_q;
							res_stat_q <= STATUS_OK;
							state_q    <= ST_FIN;
						end
					end
					ST_FIN: begin
						if (out_free) begin
							out_stat_q <= res_stat_q;
							if (res_stat_q == STATUS_OK) begin
								out_addr_q <= rsp_free_q ? '0 : res_addr_q;
								out_ord_q  <= res_ord_q;
							end else begin
								out_addr_q <= '0;
								out_ord_q  <= '0;
							end
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_CLEAR;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_free_q <= 1'b0;
		else if (in_xfer) rsp_free_q <= (req.mode == MODE_FREE);
	end

	assign req.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.address       = out_addr_q;
	assign rsp.granted_order = out_ord_q;
	assign rsp.status        = out_stat_q;

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !req.ready)
		else $error("request accepted during clear pass");

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !cfg_wr_en) |=> (state_q != ST_IDLE))
		else $error("request transfer did not start work");

	a_ok_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stat_q == STATUS_OK) |-> (out_ord_q >= MIN_O && out_ord_q <= MAX_O))
		else $error("granted order out of range");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stat_q != STATUS_OK) |-> (out_addr_q == '0 && out_ord_q == '0))
		else $error("error result carries data");

	a_fin_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !out_free && !cfg_wr_en) |=> (state_q == ST_FIN))
		else $error("result dropped while output busy");

endmodule
`default_nettype wire
